/* rtl/ppbd_pkg.sv */
// ----------------------------------------------------------------------------
// ppbd_pkg
// Shared widths, sentinels, types and the beat word passed from front to back.
// ----------------------------------------------------------------------------
package ppbd_pkg;

    localparam int SAMPLE_W      = 16;
    localparam int DECAY_W       = 16;
    localparam int PERIOD_W      = 16;
    localparam int SLOT_W        = 3;
    localparam int CNT_W         = 32;
    localparam int HISTORY_DEPTH = 8;
    localparam int HIST_IDX_W    = (HISTORY_DEPTH > 1) ? $clog2(HISTORY_DEPTH) : 1;
    localparam int QUEUE_DEPTH   = 2;
    localparam int QPTR_W        = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int QCNT_W        = $clog2(QUEUE_DEPTH + 1);

    // Peak and valley registers carry one extra bit for the sentinels.
    localparam int PEAK_W = SAMPLE_W + 1;
    // Width for doubled valley plus spread against doubled peak.
    localparam int CMP_W  = PEAK_W + 3;
    localparam int MUL_W  = SAMPLE_W + DECAY_W + 1;

    localparam logic [DECAY_W-1:0] DECAY_RESET = DECAY_W'(65470);

    localparam logic signed [PEAK_W-1:0] NEG_SENTINEL = {1'b1, {SAMPLE_W{1'b0}}};
    localparam logic signed [PEAK_W-1:0] POS_SENTINEL = {1'b0, {SAMPLE_W{1'b1}}};

    localparam logic [PERIOD_W-1:0] PERIOD_MAX = {PERIOD_W{1'b1}};

    typedef struct packed {
        logic                valid;
        logic [PERIOD_W-1:0] period;
    } t_beat;

    typedef enum logic {
        BACK_IDLE,
        BACK_EMIT
    } t_back_state;

endpackage

/* rtl/ppbd_front.sv */
// ----------------------------------------------------------------------------
// ppbd_front
// Accepts samples, follows the decaying envelopes and the peak and valley
// trackers, and pushes the saturated period of every confirmed beat.
// ----------------------------------------------------------------------------
module ppbd_front (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ppbd_pkg::SAMPLE_W-1:0] i_sample,
    input  logic                                i_cfg_we,
    input  logic        [ppbd_pkg::DECAY_W-1:0]  i_cfg_data,
    input  logic                                i_q_full,
    output ppbd_pkg::t_beat                      o_push
);

    logic        [ppbd_pkg::DECAY_W-1:0]  r_decay,      n_decay;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] r_env_min,    n_env_min;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] r_env_max,    n_env_max;
    logic                                 r_pending,    n_pending;
    logic signed [ppbd_pkg::PEAK_W-1:0]   r_best,       n_best;
    logic        [ppbd_pkg::CNT_W-1:0]    r_best_idx,   n_best_idx;
    logic signed [ppbd_pkg::PEAK_W-1:0]   r_va,         n_va;
    logic signed [ppbd_pkg::PEAK_W-1:0]   r_vb,         n_vb;
    logic        [ppbd_pkg::CNT_W-1:0]    r_prev_beat,  n_prev_beat;
    logic        [ppbd_pkg::CNT_W-1:0]    r_count,      n_count;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] r_prev,       n_prev;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] r_pprev,      n_pprev;
    logic                                 r_fresh,      n_fresh;

    // Decayed envelopes, registered from the current envelopes.
    logic signed [ppbd_pkg::SAMPLE_W-1:0] r_dec_min;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] r_dec_max;
    logic signed [ppbd_pkg::MUL_W-1:0]    w_prod_min;
    logic signed [ppbd_pkg::MUL_W-1:0]    w_prod_max;

    logic                                 w_accept;
    logic                                 w_warm;
    logic                                 w_local_max;
    logic                                 w_cand;
    logic                                 w_confirm;
    logic                                 w_beat;
    logic signed [ppbd_pkg::PEAK_W-1:0]   w_s_ext;
    logic signed [ppbd_pkg::PEAK_W-1:0]   w_prev_ext;
    logic signed [ppbd_pkg::PEAK_W-1:0]   w_va1;
    logic signed [ppbd_pkg::PEAK_W-1:0]   w_vb_min;
    logic signed [ppbd_pkg::PEAK_W-1:0]   w_vb1;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] w_min1;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] w_max1;
    logic signed [ppbd_pkg::CMP_W-1:0]    w_spread;
    logic signed [ppbd_pkg::CMP_W-1:0]    w_vb_lhs;
    logic signed [ppbd_pkg::CMP_W-1:0]    w_va_lhs;
    logic signed [ppbd_pkg::CMP_W-1:0]    w_prev2;
    logic signed [ppbd_pkg::CMP_W-1:0]    w_best2;
    logic        [ppbd_pkg::CNT_W-1:0]    w_diff;

    assign w_prod_min = ppbd_pkg::MUL_W'(r_env_min)
                      * ppbd_pkg::MUL_W'($signed({1'b0, r_decay}));
    assign w_prod_max = ppbd_pkg::MUL_W'(r_env_max)
                      * ppbd_pkg::MUL_W'($signed({1'b0, r_decay}));

    // An arithmetic shift of the product rounds toward minus infinity.
    always_ff @(posedge i_clk) begin
        r_dec_min <= w_prod_min[ppbd_pkg::DECAY_W +: ppbd_pkg::SAMPLE_W];
        r_dec_max <= w_prod_max[ppbd_pkg::DECAY_W +: ppbd_pkg::SAMPLE_W];
    end

    assign o_in_ready = r_fresh && !i_q_full;
    assign w_accept   = i_in_valid && o_in_ready;

    assign w_warm      = |r_count[ppbd_pkg::CNT_W-1:1];
    assign w_local_max = (r_prev > i_sample) && (r_prev > r_pprev);

    assign w_s_ext    = ppbd_pkg::PEAK_W'(i_sample);
    assign w_prev_ext = ppbd_pkg::PEAK_W'(r_prev);
    assign w_min1     = (i_sample < r_dec_min) ? i_sample : r_dec_min;
    assign w_max1     = (i_sample > r_dec_max) ? i_sample : r_dec_max;
    assign w_va1      = (w_s_ext < r_va) ? w_s_ext : r_va;
    assign w_vb_min   = (w_s_ext < r_vb) ? w_s_ext : r_vb;
    assign w_vb1      = r_pending ? r_vb : w_vb_min;

    // The half-spread threshold is kept exact by doubling both sides.
    assign w_spread = ppbd_pkg::CMP_W'(w_max1) - ppbd_pkg::CMP_W'(w_min1);
    assign w_vb_lhs = (ppbd_pkg::CMP_W'(w_vb1) <<< 1) + w_spread;
    assign w_va_lhs = (ppbd_pkg::CMP_W'(w_va1) <<< 1) + w_spread;
    assign w_prev2  = ppbd_pkg::CMP_W'(w_prev_ext) <<< 1;
    assign w_best2  = ppbd_pkg::CMP_W'(r_best) <<< 1;

    assign w_cand    = (r_best < w_prev_ext) && (w_vb_lhs < w_prev2);
    assign w_confirm = (w_vb_lhs < w_best2) && (w_va_lhs < w_best2);
    assign w_beat    = w_accept && w_warm && !w_local_max && r_pending && w_confirm;
    assign w_diff    = r_best_idx - r_prev_beat;

    assign o_push.valid  = w_beat;
    assign o_push.period = (|w_diff[ppbd_pkg::CNT_W-1:ppbd_pkg::PERIOD_W])
                         ? ppbd_pkg::PERIOD_MAX : w_diff[ppbd_pkg::PERIOD_W-1:0];

    always_comb begin
        n_decay     = r_decay;
        n_env_min   = r_env_min;
        n_env_max   = r_env_max;
        n_pending   = r_pending;
        n_best      = r_best;
        n_best_idx  = r_best_idx;
        n_va        = r_va;
        n_vb        = r_vb;
        n_prev_beat = r_prev_beat;
        n_count     = r_count;
        n_prev      = r_prev;
        n_pprev     = r_pprev;
        n_fresh     = 1'b1;
        // A new factor or new envelopes make the decayed values stale.
        if (i_cfg_we) begin
            n_decay = i_cfg_data;
            n_fresh = 1'b0;
        end
        if (w_accept) begin
            n_fresh   = 1'b0;
            n_env_min = w_min1;
            n_env_max = w_max1;
            n_va      = w_va1;
            n_vb      = w_vb1;
            if (w_warm && w_local_max) begin
                if (w_cand) begin
                    n_best     = w_prev_ext;
                    n_best_idx = r_count - ppbd_pkg::CNT_W'(1);
                    n_pending  = 1'b1;
                    n_vb       = (w_va1 < w_vb1) ? w_va1 : w_vb1;
                end
                n_va = ppbd_pkg::POS_SENTINEL;
            end else if (w_beat) begin
                n_best      = ppbd_pkg::NEG_SENTINEL;
                n_vb        = ppbd_pkg::POS_SENTINEL;
                n_pending   = 1'b0;
                n_prev_beat = r_best_idx;
            end
            n_pprev = r_prev;
            n_prev  = i_sample;
            n_count = r_count + ppbd_pkg::CNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_decay     <= ppbd_pkg::DECAY_RESET;
            r_env_min   <= '0;
            r_env_max   <= '0;
            r_pending   <= 1'b0;
            r_best      <= ppbd_pkg::NEG_SENTINEL;
            r_best_idx  <= '0;
            r_va        <= ppbd_pkg::POS_SENTINEL;
            r_vb        <= ppbd_pkg::POS_SENTINEL;
            r_prev_beat <= '0;
            r_count     <= '0;
            r_prev      <= '0;
            r_pprev     <= '0;
            r_fresh     <= 1'b0;
        end else begin
            r_decay     <= n_decay;
            r_env_min   <= n_env_min;
            r_env_max   <= n_env_max;
            r_pending   <= n_pending;
            r_best      <= n_best;
            r_best_idx  <= n_best_idx;
            r_va        <= n_va;
            r_vb        <= n_vb;
            r_prev_beat <= n_prev_beat;
            r_count     <= n_count;
            r_prev      <= n_prev;
            r_pprev     <= n_pprev;
            r_fresh     <= n_fresh;
        end
    end

`ifndef NO_ASSERTIONS
    // The decayed envelopes must be re-formed before the next sample.
    a_no_accept_after_accept: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> !o_in_ready
    ) else $error("front accepted a sample with stale decayed envelopes");
`endif

endmodule

/* rtl/ppbd_queue.sv */
// ----------------------------------------------------------------------------
// ppbd_queue
// Small register queue of beat periods between the front and the back.
// ----------------------------------------------------------------------------
module ppbd_queue (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  ppbd_pkg::t_beat i_push,
    output logic            o_full,
    output ppbd_pkg::t_beat o_head,
    input  logic            i_pop
);

    logic [ppbd_pkg::PERIOD_W-1:0] r_mem [ppbd_pkg::QUEUE_DEPTH];
    logic [ppbd_pkg::QPTR_W-1:0]   r_wr_ptr, n_wr_ptr;
    logic [ppbd_pkg::QPTR_W-1:0]   r_rd_ptr, n_rd_ptr;
    logic [ppbd_pkg::QCNT_W-1:0]   r_count,  n_count;
    logic                          w_push;
    logic                          w_pop;

    assign o_full        = (r_count == ppbd_pkg::QCNT_W'(ppbd_pkg::QUEUE_DEPTH));
    assign o_head.valid  = (r_count != '0);
    assign o_head.period = r_mem[r_rd_ptr];

    assign w_push = i_push.valid && !o_full;
    assign w_pop  = i_pop && o_head.valid;

    always_comb begin
        n_wr_ptr = r_wr_ptr;
        n_rd_ptr = r_rd_ptr;
        n_count  = r_count;
        if (w_push) begin
            n_wr_ptr = (r_wr_ptr == ppbd_pkg::QPTR_W'(ppbd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : r_wr_ptr + ppbd_pkg::QPTR_W'(1);
        end
        if (w_pop) begin
            n_rd_ptr = (r_rd_ptr == ppbd_pkg::QPTR_W'(ppbd_pkg::QUEUE_DEPTH - 1))
                     ? '0 : r_rd_ptr + ppbd_pkg::QPTR_W'(1);
        end
        if (w_push && !w_pop) begin
            n_count = r_count + ppbd_pkg::QCNT_W'(1);
        end else if (w_pop && !w_push) begin
            n_count = r_count - ppbd_pkg::QCNT_W'(1);
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_push) begin
            r_mem[r_wr_ptr] <= i_push.period;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_wr_ptr <= '0;
            r_rd_ptr <= '0;
            r_count  <= '0;
        end else begin
            r_wr_ptr <= n_wr_ptr;
            r_rd_ptr <= n_rd_ptr;
            r_count  <= n_count;
        end
    end

`ifndef NO_ASSERTIONS
    // The front holds its ready low while the queue is full.
    a_no_push_when_full: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        i_push.valid |-> !o_full
    ) else $error("beat word pushed into a full queue");

    a_count_bound: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        r_count <= ppbd_pkg::QCNT_W'(ppbd_pkg::QUEUE_DEPTH)
    ) else $error("queue fill count beyond its depth");
`endif

endmodule

/* rtl/ppbd_back.sv */
// ----------------------------------------------------------------------------
// ppbd_back
// Shifts each beat period into the history and reports the whole history,
// newest first, by rotating it past the output position.
// ----------------------------------------------------------------------------
module ppbd_back (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  ppbd_pkg::t_beat               i_head,
    output logic                          o_pop,
    output logic                          o_out_valid,
    input  logic                          i_out_ready,
    output logic [ppbd_pkg::SLOT_W-1:0]   o_slot,
    output logic [ppbd_pkg::PERIOD_W-1:0] o_period,
    output logic                          o_last
);

    ppbd_pkg::t_back_state r_state, n_state;

    logic [ppbd_pkg::PERIOD_W-1:0]   r_hist [ppbd_pkg::HISTORY_DEPTH];
    logic [ppbd_pkg::HIST_IDX_W-1:0] r_cnt;
    logic                            w_last;
    logic                            w_out_acc;

    assign w_last    = (r_cnt == ppbd_pkg::HIST_IDX_W'(ppbd_pkg::HISTORY_DEPTH - 1));
    assign w_out_acc = o_out_valid && i_out_ready;

    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ppbd_pkg::BACK_IDLE: begin
                if (i_head.valid) begin
                    n_state = ppbd_pkg::BACK_EMIT;
                end
            end
            ppbd_pkg::BACK_EMIT: begin
                if (i_out_ready && w_last) begin
                    n_state = ppbd_pkg::BACK_IDLE;
                end
            end
            default: n_state = ppbd_pkg::BACK_IDLE;
        endcase
    end

    always_comb begin
        o_pop       = 1'b0;
        o_out_valid = 1'b0;
        unique case (r_state)
            ppbd_pkg::BACK_IDLE: o_pop       = i_head.valid;
            ppbd_pkg::BACK_EMIT: o_out_valid = 1'b1;
            default: begin
                o_pop       = 1'b0;
                o_out_valid = 1'b0;
            end
        endcase
    end

    // The entry at position zero is always the one on the output; after a full
    // report the rotation has brought the history back into order.
    assign o_slot   = ppbd_pkg::SLOT_W'(r_cnt);
    assign o_period = r_hist[0];
    assign o_last   = w_last;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ppbd_pkg::BACK_IDLE;
            r_cnt   <= '0;
            for (int i = 0; i < ppbd_pkg::HISTORY_DEPTH; i++) begin
                r_hist[i] <= '0;
            end
        end else begin
            r_state <= n_state;
            if (o_pop) begin
                r_cnt     <= '0;
                r_hist[0] <= i_head.period;
                for (int i = 1; i < ppbd_pkg::HISTORY_DEPTH; i++) begin
                    r_hist[i] <= r_hist[i-1];
                end
            end else if (w_out_acc) begin
                r_cnt <= w_last ? '0 : r_cnt + ppbd_pkg::HIST_IDX_W'(1);
                r_hist[ppbd_pkg::HISTORY_DEPTH-1] <= r_hist[0];
                for (int i = 0; i < ppbd_pkg::HISTORY_DEPTH - 1; i++) begin
                    r_hist[i] <= r_hist[i+1];
                end
            end
        end
    end

`ifndef NO_ASSERTIONS
    // Taking the oldest entry ends the report.
    a_report_ends: assert property (
        @(posedge i_clk) disable iff (!i_rst_n)
        (w_out_acc && o_last) |=> !o_out_valid
    ) else $error("beat report ran past its oldest entry");
`endif

endmodule

/* rtl/pulse_peak_beat_detector_core.sv */
// ----------------------------------------------------------------------------
// pulse_peak_beat_detector_core
// Adaptive-threshold peak detector that reports the beat period history on
// every confirmed beat.
//
//   channel  direction  handshake                 word
//   sample   in         i_in_valid / o_in_ready   i_sample
//   report   out        o_out_valid / i_out_ready o_slot, o_period, o_last
//   config   in         i_cfg_we                  i_cfg_data (decay_factor)
//
// The front takes no new sample until the decayed envelopes have been
// re-formed through the envelope multipliers after the last one.
// A confirmed beat gives eight report words, one per cycle while the output
// is taken, once the period has been loaded into the history.
// A two-entry beat queue lets the front take samples while a report drains;
// beyond envelope re-forming, the front stalls only when the queue is full.
// Synchronous active-low reset; no clearing pass is needed.
// ----------------------------------------------------------------------------
module pulse_peak_beat_detector_core (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_in_valid,
    output logic                                o_in_ready,
    input  logic signed [ppbd_pkg::SAMPLE_W-1:0] i_sample,
    output logic                                o_out_valid,
    input  logic                                i_out_ready,
    output logic        [ppbd_pkg::SLOT_W-1:0]   o_slot,
    output logic        [ppbd_pkg::PERIOD_W-1:0] o_period,
    output logic                                o_last,
    input  logic                                i_cfg_we,
    input  logic        [ppbd_pkg::DECAY_W-1:0]  i_cfg_data
);

    ppbd_pkg::t_beat w_push;
    ppbd_pkg::t_beat w_head;
    logic            w_full;
    logic            w_pop;

    ppbd_front u_front (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_in_valid),
        .o_in_ready (o_in_ready),
        .i_sample   (i_sample),
        .i_cfg_we   (i_cfg_we),
        .i_cfg_data (i_cfg_data),
        .i_q_full   (w_full),
        .o_push     (w_push)
    );

    ppbd_queue u_queue (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_push  (w_push),
        .o_full  (w_full),
        .o_head  (w_head),
        .i_pop   (w_pop)
    );

    ppbd_back u_back (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_head      (w_head),
        .o_pop       (w_pop),
        .o_out_valid (o_out_valid),
        .i_out_ready (i_out_ready),
        .o_slot      (o_slot),
        .o_period    (o_period),
        .o_last      (o_last)
    );

endmodule

/* sim/pulse_peak_beat_detector_core_test.sv */
// ----------------------------------------------------------------------------
// pulse_peak_beat_detector_core_test
// Self-checking bench for the beat detector core. A behavioral tracker keeps
// its own envelopes, candidate peak, valleys and period history, and
// predicts every report word. The stimulus is synthetic pulse trains mixed
// with full-range noise, run over several decay settings and handshake
// idling patterns.
// ----------------------------------------------------------------------------
module pulse_peak_beat_detector_core_test;

    typedef struct packed {
        logic [ppbd_pkg::SLOT_W-1:0]   slot;
        logic [ppbd_pkg::PERIOD_W-1:0] period;
        logic                          last;
    } t_report_word;

    class beat_tracker;
        logic [ppbd_pkg::DECAY_W-1:0]         decay_factor;
        logic signed [ppbd_pkg::SAMPLE_W-1:0] env_min;
        logic signed [ppbd_pkg::SAMPLE_W-1:0] env_max;
        logic signed [ppbd_pkg::SAMPLE_W-1:0] prev_s;
        logic signed [ppbd_pkg::SAMPLE_W-1:0] prev_prev_s;
        logic signed [ppbd_pkg::PEAK_W-1:0]   best_peak;
        logic signed [ppbd_pkg::PEAK_W-1:0]   valley_after;
        logic signed [ppbd_pkg::PEAK_W-1:0]   valley_before;
        logic                                 peak_pending;
        logic [ppbd_pkg::CNT_W-1:0]           best_index;
        logic [ppbd_pkg::CNT_W-1:0]           last_beat_index;
        logic [ppbd_pkg::CNT_W-1:0]           sample_count;
        logic [ppbd_pkg::PERIOD_W-1:0]        history [ppbd_pkg::HISTORY_DEPTH];
        t_report_word                         pending_words [$];
        int                                   mismatches;
        int                                   words_checked;
        int                                   beats;
        int                                   samples;

        function new();
            decay_factor    = ppbd_pkg::DECAY_RESET;
            env_min         = '0;
            env_max         = '0;
            prev_s          = '0;
            prev_prev_s     = '0;
            best_peak       = ppbd_pkg::NEG_SENTINEL;
            valley_after    = ppbd_pkg::POS_SENTINEL;
            valley_before   = ppbd_pkg::POS_SENTINEL;
            peak_pending    = 1'b0;
            best_index      = '0;
            last_beat_index = '0;
            sample_count    = '0;
            foreach (history[i]) history[i] = '0;
            mismatches    = 0;
            words_checked = 0;
            beats         = 0;
            samples       = 0;
        endfunction

        // Arithmetic shift of the signed product is a floor division.
        function logic signed [ppbd_pkg::SAMPLE_W-1:0] decayed(
            logic signed [ppbd_pkg::SAMPLE_W-1:0] x);
            longint product;
            product = longint'(x) * longint'(decay_factor);
            return ppbd_pkg::SAMPLE_W'(product >>> 16);
        endfunction

        function void take_sample(logic signed [ppbd_pkg::SAMPLE_W-1:0] s);
            longint                     spread;
            longint                     peak2;
            logic [ppbd_pkg::CNT_W-1:0] gap;
            samples++;
            env_min = decayed(env_min);
            if (s < env_min) env_min = s;
            env_max = decayed(env_max);
            if (s > env_max) env_max = s;
            spread = longint'(env_max) - longint'(env_min);

            if (s < valley_after) valley_after = s;
            if (!peak_pending && s < valley_before) valley_before = s;

            if (sample_count > 1) begin
                if (prev_s > s && prev_s > prev_prev_s) begin
                    if (best_peak < prev_s &&
                        2 * longint'(valley_before) + spread < 2 * longint'(prev_s)) begin
                        best_peak    = prev_s;
                        best_index   = sample_count - 1;
                        peak_pending = 1'b1;
                        if (valley_after < valley_before) valley_before = valley_after;
                    end
                    valley_after = ppbd_pkg::POS_SENTINEL;
                end else if (peak_pending) begin
                    peak2 = 2 * longint'(best_peak);
                    if (2 * longint'(valley_before) + spread < peak2 &&
                        2 * longint'(valley_after) + spread < peak2) begin
                        gap             = best_index - last_beat_index;
                        best_peak       = ppbd_pkg::NEG_SENTINEL;
                        valley_before   = ppbd_pkg::POS_SENTINEL;
                        peak_pending    = 1'b0;
                        last_beat_index = best_index;
                        for (int i = ppbd_pkg::HISTORY_DEPTH - 1; i > 0; i--)
                            history[i] = history[i-1];
                        history[0] = (gap > ppbd_pkg::CNT_W'(ppbd_pkg::PERIOD_MAX))
                                   ? ppbd_pkg::PERIOD_MAX
                                   : gap[ppbd_pkg::PERIOD_W-1:0];
                        for (int i = 0; i < ppbd_pkg::HISTORY_DEPTH; i++) begin
                            t_report_word w;
                            w.slot   = ppbd_pkg::SLOT_W'(i);
                            w.period = history[i];
                            w.last   = (i == ppbd_pkg::HISTORY_DEPTH - 1);
                            pending_words.push_back(w);
                        end
                        beats++;
                    end
                end
            end

            prev_prev_s = prev_s;
            prev_s      = s;
            sample_count++;
        endfunction

        task report_mismatch(string what);
            $display("[%0t] mismatch: %s", $realtime, what);
            mismatches++;
        endtask

        task check_word(logic [ppbd_pkg::SLOT_W-1:0] slot,
                        logic [ppbd_pkg::PERIOD_W-1:0] period, logic last);
            t_report_word want;
            if (pending_words.size() == 0) begin
                report_mismatch($sformatf("unexpected word slot %0d period %0d last %0b",
                                          slot, period, last));
                return;
            end
            want = pending_words.pop_front();
            words_checked++;
            if (slot !== want.slot)
                report_mismatch($sformatf("slot %0d, wanted %0d", slot, want.slot));
            if (period !== want.period)
                report_mismatch($sformatf("period %0d at slot %0d, wanted %0d",
                                          period, want.slot, want.period));
            if (last !== want.last)
                report_mismatch($sformatf("last %0b at slot %0d, wanted %0b",
                                          last, want.slot, want.last));
        endtask
    endclass

    logic                                 clk = 1'b0;
    logic                                 rst_n = 1'b0;
    logic                                 sample_valid = 1'b0;
    logic                                 sample_ready;
    logic signed [ppbd_pkg::SAMPLE_W-1:0] sample_data = '0;
    logic                                 word_valid;
    logic                                 word_ready = 1'b0;
    logic [ppbd_pkg::SLOT_W-1:0]          word_slot;
    logic [ppbd_pkg::PERIOD_W-1:0]        word_period;
    logic                                 word_last;
    logic                                 cfg_we = 1'b0;
    logic [ppbd_pkg::DECAY_W-1:0]         cfg_data = '0;

    int sender_idle_pct   = 0;
    int receiver_idle_pct = 0;

    beat_tracker tracker = new();

    int directed_samples [20] = '{32767, -32768, 0, 20000, -20000, -20000, 32767, -1,
                                  -32768, 0, 12000, 30000, 29999, -30000, -30000,
                                  21845, -21846, 0, 0, 0};

    pulse_peak_beat_detector_core dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (sample_valid),
        .o_in_ready  (sample_ready),
        .i_sample    (sample_data),
        .o_out_valid (word_valid),
        .i_out_ready (word_ready),
        .o_slot      (word_slot),
        .o_period    (word_period),
        .o_last      (word_last),
        .i_cfg_we    (cfg_we),
        .i_cfg_data  (cfg_data)
    );

    always #10 clk = ~clk;

    always @(negedge clk) begin
        word_ready <= ($urandom_range(99) >= receiver_idle_pct);
    end

    always @(posedge clk) begin
        if (rst_n && word_valid && word_ready) begin
            tracker.check_word(word_slot, word_period, word_last);
        end
    end

    // Values beyond the sample range are clipped to it.
    task automatic send_sample(int value);
        if (value > 32767) value = 32767;
        if (value < -32768) value = -32768;
        @(negedge clk);
        while ($urandom_range(99) < sender_idle_pct) begin
            sample_valid <= 1'b0;
            @(negedge clk);
        end
        sample_valid <= 1'b1;
        sample_data  <= ppbd_pkg::SAMPLE_W'(value);
        @(posedge clk);
        while (!sample_ready) @(posedge clk);
        tracker.take_sample(ppbd_pkg::SAMPLE_W'(value));
    endtask

    task automatic send_pulse(int base, int amp, int rise, int fall, int noise);
        int jitter;
        for (int k = 1; k <= rise; k++) begin
            jitter = (noise > 0) ? int'($urandom_range(2 * noise)) - noise : 0;
            send_sample(base + amp * k / rise + jitter);
        end
        for (int k = 1; k <= fall; k++) begin
            jitter = (noise > 0) ? int'($urandom_range(2 * noise)) - noise : 0;
            send_sample(base + amp - amp * k / fall + jitter);
        end
    endtask

    // Lower valid, let every predicted word arrive, then give the block time
    // to finish a sample that produced no words.
    task automatic settle();
        @(negedge clk);
        sample_valid <= 1'b0;
        while (tracker.pending_words.size() != 0) @(posedge clk);
        repeat (24) @(posedge clk);
    endtask

    task automatic write_decay(logic [ppbd_pkg::DECAY_W-1:0] value);
        @(negedge clk);
        cfg_we   <= 1'b1;
        cfg_data <= value;
        @(negedge clk);
        cfg_we   <= 1'b0;
        tracker.decay_factor = value;
    endtask

    // Mostly clean pulses with random shape, plus full-range noise bursts and
    // ripples too small to pass the threshold.
    task automatic run_random_phase(int min_items);
        int start_beats;
        int start_samples;
        int kind;
        int amp;
        start_beats   = tracker.beats;
        start_samples = tracker.samples;
        while ((tracker.samples - start_samples < min_items ||
                tracker.beats - start_beats < 3) &&
               tracker.samples - start_samples < 60) begin
            kind = $urandom_range(99);
            if (kind < 70) begin
                amp = $urandom_range(30000, 2000);
                send_pulse(int'($urandom_range(65535 - amp)) - 32768, amp,
                           $urandom_range(8, 2), $urandom_range(10, 2), amp / 64);
            end else if (kind < 85) begin
                repeat ($urandom_range(4, 1)) send_sample(int'($urandom_range(65535)) - 32768);
            end else begin
                send_pulse(int'($urandom_range(60000)) - 30000, $urandom_range(60, 1), 2, 2, 0);
            end
        end
    endtask

    initial begin
        repeat (4) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;

        write_decay(ppbd_pkg::DECAY_RESET);
        foreach (directed_samples[i]) send_sample(directed_samples[i]);
        settle();

        sender_idle_pct = 48;
        run_random_phase(25);
        settle();

        write_decay('0);
        sender_idle_pct   = 0;
        receiver_idle_pct = 48;
        run_random_phase(25);
        settle();

        write_decay('1);
        sender_idle_pct   = 26;
        receiver_idle_pct = 26;
        run_random_phase(25);
        settle();

        write_decay(ppbd_pkg::DECAY_W'($urandom_range(65535)));
        sender_idle_pct   = 0;
        receiver_idle_pct = 0;
        run_random_phase(25);
        settle();

        if (tracker.pending_words.size() != 0)
            tracker.report_mismatch($sformatf("%0d words never arrived",
                                              tracker.pending_words.size()));
        $display("Ran %0d samples over four decay settings; %0d beats gave %0d report words.",
                 tracker.samples, tracker.beats, tracker.words_checked);
        $display("Idling covered none, the sender, the receiver and both sides.");
        if (tracker.mismatches == 0) begin
            $display("PASS pulse_peak_beat_detector_core");
        end else begin
            $display("FAIL pulse_peak_beat_detector_core");
        end
        $finish;
    end

    initial begin
        #20000000;
        $display("FAIL pulse_peak_beat_detector_core");
        $finish;
    end

endmodule
